FILE: hw/rtl/uuidp_pkg.sv
// uuidp_pkg: shared types and constants for the uuid text parser
// request payload structs, character class struct and format constants
// no dependencies
package uuidp_pkg;

    // one character of the uuid text
    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } uuidp_in_t;

    // one parse result
    typedef struct packed {
        logic        status;
        logic [63:0] uuid_high;
        logic [63:0] uuid_low;
    } uuidp_out_t;

    // decoded character class
    typedef struct packed {
        logic       is_hex;
        logic [3:0] nibble;
        logic       is_dash;
        logic       is_open;
        logic       is_close;
    } uuidp_class_t;

    localparam int unsigned POS_W = 6;

    localparam logic [POS_W-1:0] CONTENT_LEN  = 6'd36;
    localparam logic [POS_W-1:0] BRACED_LEN   = 6'd38;
    localparam logic [POS_W-1:0] POS_MAX      = 6'd63;
    localparam logic [POS_W-1:0] DASH_SLOT_0  = 6'd8;
    localparam logic [POS_W-1:0] DASH_SLOT_1  = 6'd13;
    localparam logic [POS_W-1:0] DASH_SLOT_2  = 6'd18;
    localparam logic [POS_W-1:0] DASH_SLOT_3  = 6'd23;

    localparam logic [7:0] CHAR_OPEN  = 8'h7B;
    localparam logic [7:0] CHAR_CLOSE = 8'h7D;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_F  = 8'h66;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_F  = 8'h46;

endpackage

FILE: hw/rtl/uuidp_char_class.sv
// uuidp_char_class: classifies one ascii character for the uuid parser
// gives hex digit value, dash and brace flags
// depends on uuidp_pkg
module uuidp_char_class (
    input  logic [7:0]              char_code,
    output uuidp_pkg::uuidp_class_t cls
);
    import uuidp_pkg::*;

    logic       is_dec;
    logic       is_lo;
    logic       is_up;
    logic [7:0] dec_off;
    logic [7:0] lo_off;
    logic [7:0] up_off;

    // range checks for the three digit groups
    assign is_dec  = (char_code >= CHAR_0)    && (char_code <= CHAR_9);
    assign is_lo   = (char_code >= CHAR_LO_A) && (char_code <= CHAR_LO_F);
    assign is_up   = (char_code >= CHAR_UP_A) && (char_code <= CHAR_UP_F);
    assign dec_off = char_code - CHAR_0;
    assign lo_off  = char_code - CHAR_LO_A + 8'd10;
    assign up_off  = char_code - CHAR_UP_A + 8'd10;

    // class flags and nibble value
    always_comb begin
        cls.is_hex   = is_dec || is_lo || is_up;
        cls.is_dash  = (char_code == CHAR_DASH);
        cls.is_open  = (char_code == CHAR_OPEN);
        cls.is_close = (char_code == CHAR_CLOSE);
        if (is_dec) begin
            cls.nibble = dec_off[3:0];
        end else if (is_lo) begin
            cls.nibble = lo_off[3:0];
        end else begin
            cls.nibble = up_off[3:0];
        end
    end

endmodule

FILE: hw/rtl/uuid_text_parser_core.sv
// uuid_text_parser_core: top level of the uuid text parser
// input register, per-character parse step and result register
// depends on uuidp_pkg and uuidp_char_class
//
// Usage:
//   s_valid/s_ready/s_payload carry one ascii character per request, with
//   is_last marking the final character of a string. Plain strings are 36
//   characters, braced strings 38 ('{' ... '}'), dashes at content slots
//   8, 13, 18 and 23. m_valid/m_ready/m_payload carry one result per string:
//   status 0 with the 128-bit value, or status 1 with a zero value.
//   A character accepted into the input register is parsed into state; a
//   last character's result is then visible in m_payload. Throughput: one
//   character per cycle while no last character is held, set by the
//   combinational parse step between the input and state/result registers.
//   Characters that are not last keep flowing while a result waits; a last
//   character is held in the input register until the result register
//   is free, which then back-pressures s_ready.
//   Reset (aresetn low, synchronous) empties both registers and clears the
//   position counter, brace mode, error flag and accumulated value.
module uuid_text_parser_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  uuidp_pkg::uuidp_in_t  s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output uuidp_pkg::uuidp_out_t m_payload
);
    import uuidp_pkg::*;

    logic               in_valid_reg;
    uuidp_in_t          in_data_reg;
    logic               out_valid_reg;
    uuidp_out_t         out_data_reg;

    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic               braced_reg;
    logic               braced_next;
    logic               error_reg;
    logic               error_next;
    logic [63:0]        upper_reg;
    logic [63:0]        upper_next;
    logic [63:0]        lower_reg;
    logic [63:0]        lower_next;

    uuidp_class_t       cls;
    logic [POS_W-1:0]   slot;
    logic               dash_slot;
    logic [POS_W-1:0]   expected;
    logic               bad;
    logic               out_free;
    logic               advance;

    uuidp_char_class u_class (
        .char_code (in_data_reg.char_code),
        .cls       (cls)
    );

    // handshake: a last character needs a free result slot
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!in_data_reg.is_last || out_free);
    assign s_ready  = !in_valid_reg || advance;
    assign m_valid  = out_valid_reg;
    assign m_payload = out_data_reg;

    // content slot and dash positions
    assign slot      = braced_reg ? (pos_reg - 6'd1) : pos_reg;
    assign dash_slot = (slot == DASH_SLOT_0) || (slot == DASH_SLOT_1) ||
                       (slot == DASH_SLOT_2) || (slot == DASH_SLOT_3);

    // one parse step
    always_comb begin
        braced_next = braced_reg;
        error_next  = error_reg;
        upper_next  = upper_reg;
        lower_next  = lower_reg;
        if ((pos_reg == '0) && cls.is_open) begin
            braced_next = 1'b1;
        end else if (slot < CONTENT_LEN) begin
            if (dash_slot) begin
                if (!cls.is_dash) begin
                    error_next = 1'b1;
                end
            end else if (!cls.is_hex) begin
                error_next = 1'b1;
            end else begin
                upper_next = {upper_reg[59:0], lower_reg[63:60]};
                lower_next = {lower_reg[59:0], cls.nibble};
            end
        end else if (!(braced_reg && (slot == CONTENT_LEN) && cls.is_close)) begin
            error_next = 1'b1;
        end
        pos_next = (pos_reg == POS_MAX) ? pos_reg : (pos_reg + 6'd1);
        expected = braced_next ? BRACED_LEN : CONTENT_LEN;
        bad      = error_next || (pos_next != expected);
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_data_reg <= s_payload;
        end
    end

    // parse state, cleared at the end of each string
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            braced_reg <= 1'b0;
            error_reg  <= 1'b0;
            upper_reg  <= '0;
            lower_reg  <= '0;
        end else if (advance) begin
            if (in_data_reg.is_last) begin
                pos_reg    <= '0;
                braced_reg <= 1'b0;
                error_reg  <= 1'b0;
                upper_reg  <= '0;
                lower_reg  <= '0;
            end else begin
                pos_reg    <= pos_next;
                braced_reg <= braced_next;
                error_reg  <= error_next;
                upper_reg  <= upper_next;
                lower_reg  <= lower_next;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_data_reg.is_last) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && in_data_reg.is_last) begin
            out_data_reg.status    <= bad;
            out_data_reg.uuid_high <= bad ? 64'd0 : upper_next;
            out_data_reg.uuid_low  <= bad ? 64'd0 : lower_next;
        end
    end

endmodule
